@@ sv/vkmc_pkg.sv @@
`default_nettype none

package vkmc_pkg;

    localparam int VolW   = 7;
    localparam int GuardW = 16;
    localparam int TimeW  = 32;
    localparam int CfgIdxW  = 2;
    localparam int CfgDataW = 16;

    localparam logic [VolW-1:0]   VolMax        = 7'd100;
    localparam logic [VolW-1:0]   StepReset     = 7'd5;
    localparam logic [GuardW-1:0] GuardReset    = 16'd120;
    localparam logic [VolW-1:0]   FallbackReset = 7'd70;
    localparam logic [VolW-1:0]   VolReset      = 7'd70;

    typedef enum logic [CfgIdxW-1:0] {
        CFG_STEP_SIZE  = 2'd0,
        CFG_GUARD_TIME = 2'd1,
        CFG_FALLBACK   = 2'd2
    } t_cfg_idx;

    typedef enum logic [1:0] {
        DIR_NONE = 2'd0,
        DIR_DOWN = 2'd1,
        DIR_UP   = 2'd2
    } t_dir;

    typedef enum logic [1:0] {
        EV_NONE    = 2'd0,
        EV_MUTED   = 2'd1,
        EV_UNMUTED = 2'd2,
        EV_STEP    = 2'd3
    } t_ev;

    typedef struct packed {
        logic [VolW-1:0]   step_size;
        logic [GuardW-1:0] guard_time_ms;
        logic [VolW-1:0]   fallback_volume;
    } t_cfg;

    typedef struct packed {
        logic [VolW-1:0] volume_level;
        logic            muted;
        t_ev             ev_code;
    } t_result;

endpackage

`default_nettype wire

@@ sv/vkmc_cfg.sv @@
`default_nettype none

module vkmc_cfg (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_cfg_valid,
    input  wire logic [vkmc_pkg::CfgIdxW-1:0]  i_cfg_index,
    input  wire logic [vkmc_pkg::CfgDataW-1:0] i_cfg_data,
    output vkmc_pkg::t_cfg                     o_cfg
);
    import vkmc_pkg::*;

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.step_size       <= StepReset;
            r_cfg.guard_time_ms   <= GuardReset;
            r_cfg.fallback_volume <= FallbackReset;
        end else if (i_cfg_valid) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_STEP_SIZE:  r_cfg.step_size       <= i_cfg_data[VolW-1:0];
                CFG_GUARD_TIME: r_cfg.guard_time_ms   <= i_cfg_data[GuardW-1:0];
                CFG_FALLBACK:   r_cfg.fallback_volume <= i_cfg_data[VolW-1:0];
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

@@ sv/vkmc_step.sv @@
`default_nettype none

module vkmc_step (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_en,
    input  wire logic                       i_left,
    input  wire logic                       i_right,
    input  wire logic [vkmc_pkg::TimeW-1:0] i_now,
    input  wire vkmc_pkg::t_cfg             i_cfg,
    output vkmc_pkg::t_result               o_res
);
    import vkmc_pkg::*;

    logic             r_prev_l, r_prev_r, r_prev_c, r_mute;
    logic [VolW-1:0]  r_vol, r_sav;
    t_dir             r_pd;
    logic [TimeW-1:0] r_due;

    logic             n_mute;
    logic [VolW-1:0]  n_vol, n_sav;
    t_dir             n_pd;
    logic [TimeW-1:0] n_due;
    t_ev              ev;

    logic            combo, l_edge, r_edge, c_edge;
    logic [VolW-1:0] restore;
    logic [VolW:0]   up_sum;

    assign combo   = i_left & i_right;
    assign l_edge  = i_left & ~r_prev_l;
    assign r_edge  = i_right & ~r_prev_r;
    assign c_edge  = combo & ~r_prev_c;
    assign restore = (r_sav != '0) ? r_sav : i_cfg.fallback_volume;

    always_comb begin
        n_vol  = r_vol;
        n_sav  = r_sav;
        n_mute = r_mute;
        n_pd   = r_pd;
        n_due  = r_due;
        ev     = EV_NONE;
        up_sum = '0;

        if (c_edge) begin
            n_pd  = DIR_NONE;
            n_due = '0;
            if (!r_mute) begin
                if (r_vol != '0) begin
                    n_sav = r_vol;
                end
                n_vol  = '0;
                n_mute = 1'b1;
                ev     = EV_MUTED;
            end else begin
                n_vol  = (restore > VolMax) ? VolMax : restore;
                n_mute = 1'b0;
                ev     = EV_UNMUTED;
            end
        end

        if (!combo && (l_edge || r_edge)) begin
            n_pd  = l_edge ? DIR_DOWN : DIR_UP;
            n_due = i_now + TimeW'(i_cfg.guard_time_ms);
        end

        if (combo) begin
            n_pd  = DIR_NONE;
            n_due = '0;
        end else if ((n_pd == DIR_DOWN || n_pd == DIR_UP) && i_now >= n_due) begin
            // no combo here, so n_vol still holds the stored volume
            if (n_pd == DIR_DOWN) begin
                n_vol = (n_vol > i_cfg.step_size) ? n_vol - i_cfg.step_size : '0;
            end else begin
                up_sum = {1'b0, n_vol} + {1'b0, i_cfg.step_size};
                n_vol  = (up_sum > {1'b0, VolMax}) ? VolMax : up_sum[VolW-1:0];
            end
            n_pd   = DIR_NONE;
            n_due  = '0;
            n_mute = (n_vol == '0);
            if (n_vol != '0) begin
                n_sav = n_vol;
            end
            ev = EV_STEP;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_l <= 1'b0;
            r_prev_r <= 1'b0;
            r_prev_c <= 1'b0;
            r_mute   <= 1'b0;
            r_vol    <= VolReset;
            r_sav    <= VolReset;
            r_pd     <= DIR_NONE;
            r_due    <= '0;
        end else if (i_en) begin
            r_prev_l <= i_left;
            r_prev_r <= i_right;
            r_prev_c <= combo;
            r_mute   <= n_mute;
            r_vol    <= n_vol;
            r_sav    <= n_sav;
            r_pd     <= n_pd;
            r_due    <= n_due;
        end
    end

    assign o_res = {n_vol, n_mute, ev};

    a_vol_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vol <= VolMax)
        else $error("volume above maximum");

    a_mute_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_mute |-> r_vol == '0)
        else $error("muted with nonzero volume");

    a_idle_due: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pd == DIR_NONE |-> r_due == '0)
        else $error("due time left over with no step pending");

    a_combo_cancel: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_en && combo |=> r_pd == DIR_NONE)
        else $error("step still pending after combo");

    a_combo_no_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        combo |-> ev != EV_STEP)
        else $error("step applied while combo held");

endmodule

`default_nettype wire

@@ sv/volume_keys_with_mute_combo_top.sv @@
// channel   direction  handshake                payload
// in        input      i_in_valid / o_in_stall  i_left_held, i_right_held, i_now_ms
// out       output     o_out_valid / i_out_stall o_volume_level, o_muted, o_event_code
// cfg       input      i_cfg_valid / o_cfg_ready i_cfg_index, i_cfg_data
//
// one tick per cycle sustained unless the output stalls; a tick's result shows and transfers
// only after it has passed through
// (input register, then result register, with the state update in between)
// synchronous active-low reset; the config port is always ready
// the input register doubles as a skid stage: one tick is taken while a result waits
// o_in_stall rises only when both the input and result registers hold data
`default_nettype none

module volume_keys_with_mute_combo_top (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_in_valid,
    output logic                               o_in_stall,
    input  wire logic                          i_left_held,
    input  wire logic                          i_right_held,
    input  wire logic [vkmc_pkg::TimeW-1:0]    i_now_ms,
    output logic                               o_out_valid,
    input  wire logic                          i_out_stall,
    output logic [vkmc_pkg::VolW-1:0]          o_volume_level,
    output logic                               o_muted,
    output logic [1:0]                         o_event_code,
    input  wire logic                          i_cfg_valid,
    output logic                               o_cfg_ready,
    input  wire logic [vkmc_pkg::CfgIdxW-1:0]  i_cfg_index,
    input  wire logic [vkmc_pkg::CfgDataW-1:0] i_cfg_data
);
    import vkmc_pkg::*;

    t_cfg    cfg;
    t_result res;

    logic             r_in_vld, r_out_vld;
    logic             r_in_l, r_in_r;
    logic [TimeW-1:0] r_in_t;
    t_result          r_res;
    logic             out_free, adv, in_xfer;

    assign out_free   = !r_out_vld || !i_out_stall;
    assign adv        = r_in_vld && out_free;
    assign o_in_stall = r_in_vld && !out_free;
    assign in_xfer    = i_in_valid && !o_in_stall;

    vkmc_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    vkmc_step u_step (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (adv),
        .i_left  (r_in_l),
        .i_right (r_in_r),
        .i_now   (r_in_t),
        .i_cfg   (cfg),
        .o_res   (res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (!o_in_stall) begin
                r_in_vld <= i_in_valid;
            end
            if (out_free) begin
                r_out_vld <= r_in_vld;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_in_l <= i_left_held;
            r_in_r <= i_right_held;
            r_in_t <= i_now_ms;
        end
        if (adv) begin
            r_res <= res;
        end
    end

    assign o_out_valid    = r_out_vld;
    assign o_volume_level = r_res.volume_level;
    assign o_muted        = r_res.muted;
    assign o_event_code   = r_res.ev_code;
    assign o_cfg_ready    = 1'b1;

    a_stall_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> r_out_vld && r_in_vld)
        else $error("input stalled with a free stage");

    a_adv_fills: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        adv |=> r_out_vld)
        else $error("result lost after state update");

    a_held_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_vld && i_out_stall |=> r_out_vld && $stable(r_res))
        else $error("waiting result overwritten");

endmodule

`default_nettype wire

@@ bench/volume_keys_with_mute_combo_top_tb.sv @@
`default_nettype none

module volume_keys_with_mute_combo_top_tb;
    import vkmc_pkg::*;

    localparam int WatchdogLimit = 5000;
    localparam int DirRows       = 22;
    localparam int ExpDepth      = 64;

    typedef enum logic {
        ROW_TICK,
        ROW_REGS
    } t_row_kind;

    typedef struct packed {
        t_row_kind         kind;
        logic              left;
        logic              right;
        logic [TimeW-1:0]  now;
        logic              typed;
        logic [VolW-1:0]   vol;
        logic              muted;
        t_ev               ev;
        logic [VolW-1:0]   step;
        logic [GuardW-1:0] guard;
        logic [VolW-1:0]   fallback;
    } t_dir_row;

    logic                i_clk;
    logic                i_rst_n      = 1'b0;
    logic                i_in_valid   = 1'b0;
    logic                o_in_stall;
    logic                i_left_held  = 1'b0;
    logic                i_right_held = 1'b0;
    logic [TimeW-1:0]    i_now_ms     = '0;
    logic                o_out_valid;
    logic                i_out_stall  = 1'b0;
    logic [VolW-1:0]     o_volume_level;
    logic                o_muted;
    logic [1:0]          o_event_code;
    logic                i_cfg_valid  = 1'b0;
    logic                o_cfg_ready;
    logic [CfgIdxW-1:0]  i_cfg_index  = '0;
    logic [CfgDataW-1:0] i_cfg_data   = '0;

    volume_keys_with_mute_combo_top u_top (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_left_held    (i_left_held),
        .i_right_held   (i_right_held),
        .i_now_ms       (i_now_ms),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_volume_level (o_volume_level),
        .o_muted        (o_muted),
        .o_event_code   (o_event_code),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data)
    );

    // predictor copy of the block state and registers
    logic              key_l_q;
    logic              key_r_q;
    logic              both_q;
    logic              mute_q;
    logic [VolW-1:0]   vol_q;
    logic [VolW-1:0]   saved_vol_q;
    t_dir              step_dir_q;
    logic [TimeW-1:0]  due_ms_q;
    logic [VolW-1:0]   step_amt;
    logic [GuardW-1:0] guard_ms;
    logic [VolW-1:0]   fallback_vol;

    // ring of expected reports, written at input transfers and read at output transfers
    t_result exp_ring [0:ExpDepth-1];
    int      exp_wr = 0;
    int      exp_rd = 0;

    int  mismatches    = 0;
    int  ticks_sent    = 0;
    int  reports_seen  = 0;
    int  n_muted       = 0;
    int  n_unmuted     = 0;
    int  n_steps       = 0;
    int  stall_left    = 0;
    int  quiet_cycles  = 0;
    bit  no_idle       = 1'b0;

    logic             held_l   = 1'b0;
    logic             held_r   = 1'b0;
    int               run_left = 0;
    logic [TimeW-1:0] clock_ms = '0;

    t_dir_row dir_rows [0:DirRows-1] = '{
        '{ROW_TICK, 1'b0, 1'b0, 32'd0, 1'b1, 7'd70, 1'b0, EV_NONE, 7'd0, 16'd0, 7'd0},
        '{ROW_TICK, 1'b1, 1'b0, 32'd100, 1'b0, 7'd0, 1'b0, EV_NONE, 7'd0, 16'd0, 7'd0},
        '{ROW_TICK, 1'b0, 1'b1, 32'd150, 1'b0, 7'd0, 1'b0, EV_NONE, 7'd0, 16'd0, 7'd0},
        '{ROW_TICK, 1'b1, 1'b1, 32'd200, 1'b1, 7'd0, 1'b1, EV_MUTED, 7'd0, 16'd0, 7'd0},
        '{ROW_TICK, 1'b1, 1'b1, 32'd400, 1'b0, 7'd0, 1'b0, EV_NONE, 7'd0, 16'd0, 7'd0},
        '{ROW_TICK, 1'b0, 1'b0, 32'd410, 1'b0, 7'd0, 1'b0, EV_NONE, 7'd0, 16'd0, 7'd0},
        '{ROW_TICK, 1'b1, 1'b1, 32'd420, 1'b1, 7'd70, 1'b0, EV_UNMUTED, 7'd0, 16'd0, 7'd0},
        '{ROW_REGS, 1'b0, 1'b0, 32'd0, 1'b0, 7'd0, 1'b0, EV_NONE, 7'd127, 16'd0, 7'd127},
        '{ROW_TICK, 1'b0, 1'b0, 32'd500, 1'b0, 7'd0, 1'b0, EV_NONE, 7'd0, 16'd0, 7'd0},
        '{ROW_TICK, 1'b0, 1'b1, 32'd501, 1'b1, 7'd100, 1'b0, EV_STEP, 7'd0, 16'd0, 7'd0},
        '{ROW_TICK, 1'b1, 1'b0, 32'd502, 1'b1, 7'd0, 1'b1, EV_STEP, 7'd0, 16'd0, 7'd0},
        '{ROW_TICK, 1'b1, 1'b1, 32'd503, 1'b0, 7'd0, 1'b0, EV_NONE, 7'd0, 16'd0, 7'd0},
        '{ROW_REGS, 1'b0, 1'b0, 32'd0, 1'b0, 7'd0, 1'b0, EV_NONE, 7'd0, 16'd0, 7'd0},
        '{ROW_TICK, 1'b0, 1'b0, 32'd504, 1'b0, 7'd0, 1'b0, EV_NONE, 7'd0, 16'd0, 7'd0},
        '{ROW_TICK, 1'b1, 1'b0, 32'd505, 1'b1, 7'd100, 1'b0, EV_STEP, 7'd0, 16'd0, 7'd0},
        '{ROW_REGS, 1'b0, 1'b0, 32'd0, 1'b0, 7'd0, 1'b0, EV_NONE, 7'd5, 16'hFFFF, 7'd70},
        '{ROW_TICK, 1'b0, 1'b0, 32'hFFFFFFF0, 1'b0, 7'd0, 1'b0, EV_NONE, 7'd0, 16'd0, 7'd0},
        '{ROW_TICK, 1'b0, 1'b1, 32'hFFFFFFFF, 1'b1, 7'd100, 1'b0, EV_STEP, 7'd0, 16'd0, 7'd0},
        '{ROW_TICK, 1'b0, 1'b0, 32'd0, 1'b1, 7'd100, 1'b0, EV_NONE, 7'd0, 16'd0, 7'd0},
        '{ROW_TICK, 1'b1, 1'b0, 32'd0, 1'b0, 7'd0, 1'b0, EV_NONE, 7'd0, 16'd0, 7'd0},
        '{ROW_TICK, 1'b1, 1'b0, 32'd65534, 1'b0, 7'd0, 1'b0, EV_NONE, 7'd0, 16'd0, 7'd0},
        '{ROW_TICK, 1'b0, 1'b0, 32'd65535, 1'b1, 7'd95, 1'b0, EV_STEP, 7'd0, 16'd0, 7'd0}
    };

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    task automatic reset_keys_model();
        key_l_q      = 1'b0;
        key_r_q      = 1'b0;
        both_q       = 1'b0;
        mute_q       = 1'b0;
        vol_q        = VolReset;
        saved_vol_q  = VolReset;
        step_dir_q   = DIR_NONE;
        due_ms_q     = '0;
        step_amt     = StepReset;
        guard_ms     = GuardReset;
        fallback_vol = FallbackReset;
    endtask

    function automatic logic [VolW-1:0] clamp_volume(int v);
        return (v > int'(VolMax)) ? VolMax : VolW'(v);
    endfunction

    // one frame tick through the predictor, returns the report it should produce
    function automatic t_result advance_keys(logic l, logic r, logic [TimeW-1:0] now);
        logic    both;
        logic    l_rise;
        logic    r_rise;
        logic    both_rise;
        t_ev     ev;
        t_result res;
        both      = l & r;
        l_rise    = l & ~key_l_q;
        r_rise    = r & ~key_r_q;
        both_rise = both & ~both_q;
        ev        = EV_NONE;
        key_l_q   = l;
        key_r_q   = r;
        both_q    = both;

        if (both_rise) begin
            step_dir_q = DIR_NONE;
            due_ms_q   = '0;
            if (!mute_q) begin
                if (vol_q != 0)
                    saved_vol_q = vol_q;
                vol_q  = '0;
                mute_q = 1'b1;
                ev     = EV_MUTED;
            end else begin
                vol_q  = clamp_volume((saved_vol_q != 0) ? int'(saved_vol_q)
                                                         : int'(fallback_vol));
                mute_q = 1'b0;
                ev     = EV_UNMUTED;
            end
        end

        if (!both && (l_rise || r_rise)) begin
            step_dir_q = l_rise ? DIR_DOWN : DIR_UP;
            due_ms_q   = now + {{(TimeW-GuardW){1'b0}}, guard_ms};
        end

        if (both) begin
            step_dir_q = DIR_NONE;
            due_ms_q   = '0;
        end else if ((step_dir_q == DIR_DOWN || step_dir_q == DIR_UP) && now >= due_ms_q) begin
            if (step_dir_q == DIR_DOWN)
                vol_q = (vol_q > step_amt) ? vol_q - step_amt : '0;
            else
                vol_q = clamp_volume(int'(vol_q) + int'(step_amt));
            step_dir_q = DIR_NONE;
            due_ms_q   = '0;
            mute_q     = (vol_q == 0);
            if (vol_q != 0)
                saved_vol_q = vol_q;
            ev = EV_STEP;
        end

        res.volume_level = vol_q;
        res.muted        = mute_q;
        res.ev_code      = ev;
        return res;
    endfunction

    // mostly short gaps, now and then a long one
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 85)
            return $urandom_range(1, 3);
        else if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    task automatic send_tick(logic l, logic r, logic [TimeW-1:0] now, logic typed,
                             t_result typed_res);
        t_result want;
        int      gap;
        i_in_valid   <= 1'b1;
        i_left_held  <= l;
        i_right_held <= r;
        i_now_ms     <= now;
        do @(posedge i_clk); while (o_in_stall);
        want = advance_keys(l, r, now);
        exp_ring[exp_wr % ExpDepth] = typed ? typed_res : want;
        exp_wr++;
        ticks_sent++;
        gap = no_idle ? 0 : (($urandom_range(0, 3) == 0) ? pick_gap() : 0);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // stop sending and let every outstanding report come back
    task automatic wait_idle();
        i_in_valid <= 1'b0;
        while (exp_wr != exp_rd)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // all three registers back to back, valid held high across the transfers
    task automatic write_regs(logic [VolW-1:0] step, logic [GuardW-1:0] guard,
                              logic [VolW-1:0] fb);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= CFG_STEP_SIZE;
        i_cfg_data  <= CfgDataW'(step);
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_index <= CFG_GUARD_TIME;
        i_cfg_data  <= CfgDataW'(guard);
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_index <= CFG_FALLBACK;
        i_cfg_data  <= CfgDataW'(fb);
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid  <= 1'b0;
        step_amt     = step;
        guard_ms     = guard;
        fallback_vol = fb;
    endtask

    // key levels held in runs so that presses, releases and combos form real gestures
    task automatic next_keys();
        int r;
        if (run_left == 0) begin
            r = $urandom_range(0, 9);
            run_left = $urandom_range(1, 5);
            case (r)
                0, 1, 2: begin held_l = 1'b0; held_r = 1'b0; end
                3, 4:    begin held_l = 1'b1; held_r = 1'b0; end
                5, 6:    begin held_l = 1'b0; held_r = 1'b1; end
                7, 8:    begin held_l = 1'b1; held_r = 1'b1; end
                default: begin
                    held_l   = 1'($urandom_range(0, 1));
                    held_r   = 1'($urandom_range(0, 1));
                    run_left = 1;
                end
            endcase
        end
        run_left--;
    endtask

    task automatic next_time();
        int r;
        r = $urandom_range(0, 99);
        if (r < 2)
            clock_ms = $urandom;
        else if (r < 3)
            clock_ms = 32'hFFFF_FFFF - $urandom_range(0, 200);
        else
            clock_ms = clock_ms + $urandom_range(0, int'(guard_ms) / 3 + 20);
    endtask

    task automatic run_ticks(int n);
        for (int i = 0; i < n; i++) begin
            if (i == n / 2)
                wait_idle();
            next_keys();
            next_time();
            send_tick(held_l, held_r, clock_ms, 1'b0, '0);
        end
    endtask

    always @(posedge i_clk) begin
        if (stall_left > 0)
            stall_left--;
        else if (!no_idle && $urandom_range(0, 4) == 0)
            stall_left = pick_gap();
        i_out_stall <= (stall_left > 0);
    end

    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            reports_seen++;
            case (o_event_code)
                EV_MUTED:   n_muted++;
                EV_UNMUTED: n_unmuted++;
                EV_STEP:    n_steps++;
                default:    ;
            endcase
            if (exp_wr == exp_rd) begin
                if (mismatches < 10)
                    $display("unexpected report: vol %0d muted %0d ev %0d",
                             o_volume_level, o_muted, o_event_code);
                mismatches++;
            end else begin
                want = exp_ring[exp_rd % ExpDepth];
                exp_rd++;
                if (o_volume_level !== want.volume_level || o_muted !== want.muted ||
                    o_event_code !== want.ev_code) begin
                    if (mismatches < 10)
                        $display({"report mismatch: exp vol %0d muted %0d ev %0d, ",
                                  "got vol %0d muted %0d ev %0d"},
                                 want.volume_level, want.muted, want.ev_code,
                                 o_volume_level, o_muted, o_event_code);
                    mismatches++;
                end
            end
        end
    end

    // watchdog on cycles without any transfer
    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall) ||
            (i_cfg_valid && o_cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WatchdogLimit) begin
            $display("volume_keys_with_mute_combo_top_tb: done, errors");
            $finish;
        end
    end

    initial begin
        logic [VolW-1:0]   p_step;
        logic [GuardW-1:0] p_guard;
        logic [VolW-1:0]   p_fb;
        int                p_len;
        t_result           typed_res;

        reset_keys_model();
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int i = 0; i < DirRows; i++) begin
            if (dir_rows[i].kind == ROW_REGS) begin
                wait_idle();
                write_regs(dir_rows[i].step, dir_rows[i].guard, dir_rows[i].fallback);
            end else begin
                typed_res = '{dir_rows[i].vol, dir_rows[i].muted, dir_rows[i].ev};
                send_tick(dir_rows[i].left, dir_rows[i].right, dir_rows[i].now,
                          dir_rows[i].typed, typed_res);
            end
        end

        clock_ms = 32'd1000;
        for (int p = 0; p < 5; p++) begin
            wait_idle();
            case (p)
                0: begin p_step = 7'd5;   p_guard = 16'd120;   p_fb = 7'd70;  p_len = 150; end
                1: begin p_step = 7'd1;   p_guard = 16'd0;     p_fb = 7'd0;   p_len = 150; end
                2: begin p_step = 7'd100; p_guard = 16'hFFFF;  p_fb = 7'd100; p_len = 120; end
                3: begin p_step = 7'd127; p_guard = 16'd37;    p_fb = 7'd127; p_len = 150; end
                default: begin
                    p_step  = VolW'($urandom_range(0, 127));
                    p_guard = GuardW'($urandom_range(0, 300));
                    p_fb    = VolW'($urandom_range(0, 127));
                    p_len   = 180;
                end
            endcase
            write_regs(p_step, p_guard, p_fb);
            // back-to-back transfers on both sides for one phase
            no_idle = (p == 1);
            run_ticks(p_len);
        end
        no_idle = 1'b0;
        wait_idle();
        repeat (10) @(posedge i_clk);

        $display("ticks sent %0d, reports checked %0d, mismatches %0d",
                 ticks_sent, reports_seen, mismatches);
        $display("mutes %0d, unmutes %0d, volume steps %0d over the directed rows and %0s",
                 n_muted, n_unmuted, n_steps, "five random phases with their own registers");
        if (mismatches == 0)
            $display("volume_keys_with_mute_combo_top_tb: done, clean");
        else
            $display("volume_keys_with_mute_combo_top_tb: done, errors");
        $finish;
    end

endmodule

`default_nettype wire

@@ volume_keys_with_mute_combo_top.f @@
sv/vkmc_pkg.sv
sv/vkmc_cfg.sv
sv/vkmc_step.sv
sv/volume_keys_with_mute_combo_top.sv
bench/volume_keys_with_mute_combo_top_tb.sv
